// ===== rtl/wsfd_pkg.sv =====
// package for the websocket frame deframer
// result beat type, length width, error codes and header length codes
// no dependencies
`timescale 1ns / 1ps

package wsfd_pkg;

    // width of the payload length counter
    localparam int unsigned LENGTH_BITS = 64;

    // error codes on a result beat
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_MASKED     = 2'd1;
    localparam logic [1:0] ERR_COMPRESSED = 2'd2;

    // seven bit length codes that pull an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // extended length byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       has_data;
        logic [3:0] msg_opcode;
        logic       compressed;
        logic       last;
        logic [1:0] error;
    } t_result;

endpackage

// ===== rtl/wsfd_parser.sv =====
// frame header parser and payload tagger for the websocket frame deframer
// one accepted byte per cycle in, at most one result per byte out (combinational)
// depends on wsfd_pkg
`timescale 1ns / 1ps

module wsfd_parser import wsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_deflate_en,
    output t_result    o_res
);

    localparam logic [1:0] PH_HDR0 = 2'd0;
    localparam logic [1:0] PH_HDR1 = 2'd1;
    localparam logic [1:0] PH_EXT  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]             r_phase, n_phase;
    logic [3:0]             r_ext_left, n_ext_left;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic                   r_frame_final, n_frame_final;
    logic [3:0]             r_msg_opcode, n_msg_opcode;
    logic                   r_msg_comp, n_msg_comp;
    logic                   r_in_cont, n_in_cont;
    logic                   r_halted, n_halted;
    logic                   hdr_done;

    always_comb begin
        n_phase       = r_phase;
        n_ext_left    = r_ext_left;
        n_remaining   = r_remaining;
        n_frame_final = r_frame_final;
        n_msg_opcode  = r_msg_opcode;
        n_msg_comp    = r_msg_comp;
        n_in_cont     = r_in_cont;
        n_halted      = r_halted;
        hdr_done      = 1'b0;

        o_res            = '0;
        o_res.msg_opcode = r_msg_opcode;
        o_res.compressed = r_msg_comp;
        o_res.error      = ERR_NONE;

        if (i_valid && !r_halted) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_frame_final = i_byte[7];
                    // continuation frames keep the first frame's opcode and rsv1
                    if (!r_in_cont) begin
                        n_msg_opcode = i_byte[3:0];
                        n_msg_comp   = i_byte[6];
                    end
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    if (i_byte[7]) begin
                        n_halted    = 1'b1;
                        o_res.valid = 1'b1;
                        o_res.error = ERR_MASKED;
                    end else if (!r_in_cont && r_msg_comp && !i_deflate_en) begin
                        n_halted    = 1'b1;
                        o_res.valid = 1'b1;
                        o_res.error = ERR_COMPRESSED;
                    end else begin
                        n_remaining = '0;
                        if (i_byte[6:0] == LEN_EXT16) begin
                            n_ext_left = EXT16_BYTES;
                            n_phase    = PH_EXT;
                        end else if (i_byte[6:0] == LEN_EXT64) begin
                            n_ext_left = EXT64_BYTES;
                            n_phase    = PH_EXT;
                        end else begin
                            n_remaining = {{(LENGTH_BITS-7){1'b0}}, i_byte[6:0]};
                            hdr_done    = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    // big-endian shift in, saturating when the top byte is in use
                    if (|r_remaining[LENGTH_BITS-1 -: 8]) begin
                        n_remaining = '1;
                    end else begin
                        n_remaining = {r_remaining[LENGTH_BITS-9:0], i_byte};
                    end
                    n_ext_left = r_ext_left - 4'd1;
                    hdr_done   = (n_ext_left == 4'd0);
                end
                PH_DATA: begin
                    n_remaining     = r_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    o_res.valid     = 1'b1;
                    o_res.data_byte = i_byte;
                    o_res.has_data  = 1'b1;
                    if (r_remaining == {{(LENGTH_BITS-1){1'b0}}, 1'b1}) begin
                        n_phase    = PH_HDR0;
                        n_in_cont  = !r_frame_final;
                        o_res.last = r_frame_final;
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase

            // header complete: payload follows, or the frame is empty
            if (hdr_done) begin
                if (n_remaining != '0) begin
                    n_phase = PH_DATA;
                end else begin
                    n_phase   = PH_HDR0;
                    n_in_cont = !r_frame_final;
                    if (r_frame_final) begin
                        o_res.valid = 1'b1;
                        o_res.last  = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_ext_left    <= '0;
            r_remaining   <= '0;
            r_frame_final <= 1'b0;
            r_msg_opcode  <= '0;
            r_msg_comp    <= 1'b0;
            r_in_cont     <= 1'b0;
            r_halted      <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_ext_left    <= n_ext_left;
            r_remaining   <= n_remaining;
            r_frame_final <= n_frame_final;
            r_msg_opcode  <= n_msg_opcode;
            r_msg_comp    <= n_msg_comp;
            r_in_cont     <= n_in_cont;
            r_halted      <= n_halted;
        end
    end

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
// top level of the websocket frame deframer: byte stream in, tagged payload stream out
// holds the config register, the output register and the skid stage
// depends on wsfd_pkg and wsfd_parser
`timescale 1ns / 1ps

// channel     | dir | beat contents
// ------------+-----+------------------------------------------------------------
// s_axis      | in  | tdata[7:0] rx_byte
// m_axis      | out | tdata: data_byte, msg_opcode_out, compressed; tuser: has_data,
//             |     | error; tlast: last
// apb         | in  | reg 0 at byte address 0: deflate_enabled (bit 0)
//
// one byte is taken per cycle while tready is high; the parser decides each byte in the cycle it
// is accepted and the result lands in the output register or the skid stage on the same edge; a
// skid stage behind the output register keeps the input open for one more beat while a result
// waits; tready drops only when the skid stage is full; header and extended length bytes give no
// beat, but a masked or barred compressed header gives an error beat and an empty final frame a
// last beat; payload bytes give one each; synchronous active-low reset clears parser state, the
// register and both stages; after a masked or disallowed compressed frame the parser drops all bytes until reset

module websocket_frame_deframer_unit import wsfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] data_byte, [11:8] msg_opcode_out,
                                          // [12] compressed, [15:13] unused
    output logic        o_m_axis_tlast,   // last
    output logic [2:0]  o_m_axis_tuser,   // [0] has_data, [2:1] error
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    r_deflate_en;
    t_result parse_res;
    logic    in_accept;
    logic    out_take;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    // config register: writes land on the access phase, reads are combinational
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_deflate_en} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deflate_en <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_deflate_en <= pwdata[0];
        end
    end

    // input side stays open as long as the skid stage is free
    assign o_s_axis_tready = !r_skid_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    wsfd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_accept),
        .i_byte       (i_s_axis_tdata),
        .i_deflate_en (r_deflate_en),
        .o_res        (parse_res)
    );

    assign out_take = r_out_valid && i_m_axis_tready;

    // output register plus skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // no new beat comes in while the skid stage is full
            if (out_take) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (parse_res.valid) begin
            if (!r_out_valid || out_take) begin
                n_out       = parse_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = parse_res;
                n_skid_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload registers need no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.compressed, r_out.msg_opcode, r_out.data_byte};
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tuser  = {r_out.error, r_out.has_data};

endmodule
